// ===== rtl/hbs_pkg.sv =====
package hbs_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int IDX_W       = $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT);
	localparam int SIZE_W      = IDX_W + 1;
	localparam int CFG_SIZE_W  = 11;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int TADDR_W     = 20;
	localparam int TEXEL_W     = 8;
	localparam int COORD_W     = 32;

	localparam int FRAC_W  = 16;
	localparam int QB      = IDX_W + FRAC_W;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = DIFF_W + IDX_W;
	localparam int DIV_LAT = QB + 1;

	localparam int WSING_W = FRAC_W + 1;
	localparam int WGT_W   = 2 * FRAC_W + 1;
	localparam int SUM_W   = WGT_W + TEXEL_W;
	localparam int Y_W     = SUM_W - FRAC_W;

	localparam logic [SUM_W-1:0]   RND_C    = SUM_W'(25 * 65536);
	localparam int                 RECIP_W  = 26;
	localparam logic [RECIP_W-1:0] RECIP_C  = RECIP_W'(42949673);
	localparam int                 RECIP_SH = 31;
	localparam int                 MQ_W     = Y_W + RECIP_W;

	localparam int              HEIGHT_W   = 19;
	localparam logic [HEIGHT_W-1:0] HEIGHT_OFF = HEIGHT_W'(131072);

	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_DEPTH   = 4;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [2:0] CFG_ORIGIN_X   = 3'd0;
	localparam logic [2:0] CFG_ORIGIN_Y   = 3'd1;
	localparam logic [2:0] CFG_EXTENT_X   = 3'd2;
	localparam logic [2:0] CFG_EXTENT_Y   = 3'd3;
	localparam logic [2:0] CFG_MAP_WIDTH  = 3'd4;
	localparam logic [2:0] CFG_MAP_HEIGHT = 3'd5;

	typedef struct packed {
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic signed [COORD_W-1:0] extent_x;
		logic signed [COORD_W-1:0] extent_y;
		logic [CFG_SIZE_W-1:0]     map_width;
		logic [CFG_SIZE_W-1:0]     map_height;
	} cfg_t;

	typedef struct packed {
		logic                        is_query;
		logic                        wr_ok;
		logic [TEXEL_W-1:0]          value;
		logic [3:0][ADDR_W-1:0]      addr;
		logic [3:0][WGT_W-1:0]       wgt;
	} entry_t;

endpackage

// ===== rtl/hbs_divider.sv =====
module hbs_divider (
	input  logic                        clk,
	input  logic                        en,
	input  logic [hbs_pkg::PROD_W-1:0]  p,
	input  logic [hbs_pkg::DIFF_W-1:0]  d,
	output logic [hbs_pkg::QB-1:0]      q,
	output logic                        sat
);

	localparam int QB    = hbs_pkg::QB;
	localparam int REM_W = hbs_pkg::DIFF_W;
	localparam int IDX_W = hbs_pkg::IDX_W;

	logic [REM_W-1:0] rem_q [0:QB];
	logic [QB-1:0]    low_q [0:QB];
	logic [QB-1:0]    quo_q [0:QB];
	logic [REM_W-1:0] d_q   [0:QB];
	logic             sat_q [0:QB];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= p[hbs_pkg::PROD_W-1:IDX_W];
			low_q[0] <= {p[IDX_W-1:0], {hbs_pkg::FRAC_W{1'b0}}};
			quo_q[0] <= '0;
			d_q[0]   <= d;
			sat_q[0] <= (p[hbs_pkg::PROD_W-1:IDX_W] >= d);
		end
	end

	for (genvar i = 1; i <= QB; i++) begin : g_step
		logic [REM_W:0] r2;
		logic           ge;
		assign r2 = {rem_q[i-1], low_q[i-1][QB-1]};
		assign ge = (r2 >= {1'b0, d_q[i-1]});
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= ge ? REM_W'(r2 - {1'b0, d_q[i-1]}) : r2[REM_W-1:0];
				low_q[i] <= {low_q[i-1][QB-2:0], 1'b0};
				quo_q[i] <= {quo_q[i-1][QB-2:0], ge};
				d_q[i]   <= d_q[i-1];
				sat_q[i] <= sat_q[i-1];
			end
		end
	end

	assign q   = quo_q[QB];
	assign sat = sat_q[QB];

endmodule

// ===== rtl/hbs_front.sv =====
module hbs_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hbs_pkg::cfg_t                cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         in_type,
	input  logic [hbs_pkg::TADDR_W-1:0]  in_addr,
	input  logic [hbs_pkg::TEXEL_W-1:0]  in_value,
	input  logic signed [31:0]           in_qx,
	input  logic signed [31:0]           in_qy,
	output logic                         push,
	output hbs_pkg::entry_t              push_entry,
	input  logic                         full
);

	localparam int IDX_W   = hbs_pkg::IDX_W;
	localparam int SIZE_W  = hbs_pkg::SIZE_W;
	localparam int ADDR_W  = hbs_pkg::ADDR_W;
	localparam int DIFF_W  = hbs_pkg::DIFF_W;
	localparam int FRAC_W  = hbs_pkg::FRAC_W;
	localparam int QB      = hbs_pkg::QB;
	localparam int WSING_W = hbs_pkg::WSING_W;
	localparam int WGT_W   = hbs_pkg::WGT_W;
	localparam int DIV_LAT = hbs_pkg::DIV_LAT;

	typedef struct packed {
		logic                       is_query;
		logic                       wr_ok;
		logic [ADDR_W-1:0]          addr;
		logic [hbs_pkg::TEXEL_W-1:0] value;
		logic [SIZE_W-1:0]          w;
		logic [SIZE_W-1:0]          h;
		logic                       clr_x;
		logic                       clr_y;
	} pay_t;

	typedef struct packed {
		logic [IDX_W-1:0]  c0;
		logic [IDX_W-1:0]  c1;
		logic [FRAC_W-1:0] f;
	} axis_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [hbs_pkg::CFG_SIZE_W-1:0] v,
			input int maxv);
		logic [SIZE_W:0] vx;
		vx = (SIZE_W+1)'(v);
		if (vx < (SIZE_W+1)'(2))
			return SIZE_W'(2);
		else if (vx > (SIZE_W+1)'(maxv))
			return SIZE_W'(maxv);
		else
			return vx[SIZE_W-1:0];
	endfunction

	function automatic axis_t split_axis(input logic [QB-1:0] q, input logic sat,
			input logic clr, input logic [SIZE_W-1:0] size);
		axis_t            r;
		logic [IDX_W-1:0] last;
		logic [IDX_W-1:0] base;
		logic [IDX_W:0]   b1;
		last = IDX_W'(size - SIZE_W'(1));
		base = q[QB-1:FRAC_W];
		b1   = {1'b0, base} + (IDX_W+1)'(1);
		r.f  = '0;
		if (clr) begin
			r.c0 = '0;
			r.c1 = '0;
		end else if (sat) begin
			r.c0 = last;
			r.c1 = last;
		end else begin
			r.c0 = (base > last) ? last : base;
			r.c1 = (b1 > {1'b0, last}) ? last : b1[IDX_W-1:0];
			r.f  = q[FRAC_W-1:0];
		end
		return r;
	endfunction

	logic en;
	logic v_s1, v_s2, v_s3, v_s5, v_s6, v_s7;
	logic v_dl_q [DIV_LAT];
	pay_t pay_s1, pay_s2, pay_s3, pay_s5, pay_s6;
	pay_t pay_dl_q [DIV_LAT];

	logic signed [DIFF_W-1:0] nx_s1, dx_s1, ny_s1, dy_s1;
	logic [DIFF_W-1:0] mnx_s2, mdx_s2, mny_s2, mdy_s2;
	logic [IDX_W-1:0]  spx_s2, spy_s2;
	logic [hbs_pkg::PROD_W-1:0] px_s3, py_s3;
	logic [DIFF_W-1:0] dx_s3, dy_s3;
	logic [QB-1:0]     qx_d, qy_d;
	logic              satx_d, saty_d;
	axis_t             ax_s5, ay_s5;
	logic [ADDR_W-1:0] rw0_s6, rw1_s6;
	logic [IDX_W-1:0]  c0_s6, c1_s6;
	logic [3:0][WGT_W-1:0] wgt_s6;
	hbs_pkg::entry_t   entry_s7;
	logic [WSING_W-1:0] wu0, wu1, wv0, wv1;

	assign en       = !v_s7 || !full;
	assign in_ready = en;
	assign push     = v_s7 && !full;
	assign push_entry = entry_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) v_dl_q[i] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_dl_q[0] <= v_s3;
			for (int i = 1; i < DIV_LAT; i++) v_dl_q[i] <= v_dl_q[i-1];
			v_s5 <= v_dl_q[DIV_LAT-1];
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s1.is_query <= (in_type == hbs_pkg::REQ_QUERY);
			pay_s1.wr_ok    <= ({1'b0, in_addr} < 33'(hbs_pkg::STORE_DEPTH));
			pay_s1.addr     <= ADDR_W'(in_addr);
			pay_s1.value    <= in_value;
			pay_s1.w        <= clamp_size(cfg.map_width, hbs_pkg::MAX_WIDTH);
			pay_s1.h        <= clamp_size(cfg.map_height, hbs_pkg::MAX_HEIGHT);
			pay_s1.clr_x    <= 1'b0;
			pay_s1.clr_y    <= 1'b0;
			nx_s1 <= {in_qx[31], in_qx} - {cfg.origin_x[31], cfg.origin_x};
			dx_s1 <= {cfg.extent_x[31], cfg.extent_x} - {cfg.origin_x[31], cfg.origin_x};
			ny_s1 <= {in_qy[31], in_qy} - {cfg.origin_y[31], cfg.origin_y};
			dy_s1 <= {cfg.extent_y[31], cfg.extent_y} - {cfg.origin_y[31], cfg.origin_y};

			pay_s2 <= {pay_s1.is_query, pay_s1.wr_ok, pay_s1.addr, pay_s1.value,
				pay_s1.w, pay_s1.h,
				((nx_s1[DIFF_W-1] != dx_s1[DIFF_W-1]) && (nx_s1 != '0)) || (dx_s1 == '0),
				((ny_s1[DIFF_W-1] != dy_s1[DIFF_W-1]) && (ny_s1 != '0)) || (dy_s1 == '0)};
			mnx_s2 <= nx_s1[DIFF_W-1] ? DIFF_W'(-nx_s1) : DIFF_W'(nx_s1);
			mdx_s2 <= dx_s1[DIFF_W-1] ? DIFF_W'(-dx_s1) : DIFF_W'(dx_s1);
			mny_s2 <= ny_s1[DIFF_W-1] ? DIFF_W'(-ny_s1) : DIFF_W'(ny_s1);
			mdy_s2 <= dy_s1[DIFF_W-1] ? DIFF_W'(-dy_s1) : DIFF_W'(dy_s1);
			spx_s2 <= IDX_W'(pay_s1.w - SIZE_W'(1));
			spy_s2 <= IDX_W'(pay_s1.h - SIZE_W'(1));

			pay_s3 <= pay_s2;
			px_s3  <= mnx_s2 * spx_s2;
			py_s3  <= mny_s2 * spy_s2;
			dx_s3  <= mdx_s2;
			dy_s3  <= mdy_s2;

			pay_dl_q[0] <= pay_s3;
			for (int i = 1; i < DIV_LAT; i++) pay_dl_q[i] <= pay_dl_q[i-1];

			pay_s5 <= pay_dl_q[DIV_LAT-1];
			ax_s5  <= split_axis(qx_d, satx_d, pay_dl_q[DIV_LAT-1].clr_x,
				pay_dl_q[DIV_LAT-1].w);
			ay_s5  <= split_axis(qy_d, saty_d, pay_dl_q[DIV_LAT-1].clr_y,
				pay_dl_q[DIV_LAT-1].h);

			pay_s6 <= pay_s5;
			rw0_s6 <= ADDR_W'(ay_s5.c0) * ADDR_W'(pay_s5.w);
			rw1_s6 <= ADDR_W'(ay_s5.c1) * ADDR_W'(pay_s5.w);
			c0_s6  <= ax_s5.c0;
			c1_s6  <= ax_s5.c1;
			wgt_s6[0] <= wu0 * wv0;
			wgt_s6[1] <= wu0 * wv1;
			wgt_s6[2] <= wu1 * wv0;
			wgt_s6[3] <= wu1 * wv1;

			entry_s7.is_query <= pay_s6.is_query;
			entry_s7.wr_ok    <= pay_s6.wr_ok;
			entry_s7.value    <= pay_s6.value;
			entry_s7.wgt      <= wgt_s6;
			entry_s7.addr[0]  <= pay_s6.is_query ? rw0_s6 + ADDR_W'(c0_s6) : pay_s6.addr;
			entry_s7.addr[1]  <= rw1_s6 + ADDR_W'(c0_s6);
			entry_s7.addr[2]  <= rw0_s6 + ADDR_W'(c1_s6);
			entry_s7.addr[3]  <= rw1_s6 + ADDR_W'(c1_s6);
		end
	end

	assign wu0 = WSING_W'(65536) - {1'b0, ax_s5.f};
	assign wu1 = {1'b0, ax_s5.f};
	assign wv0 = WSING_W'(65536) - {1'b0, ay_s5.f};
	assign wv1 = {1'b0, ay_s5.f};

	hbs_divider u_div_x (
		.clk (clk),
		.en  (en),
		.p   (px_s3),
		.d   (dx_s3),
		.q   (qx_d),
		.sat (satx_d)
	);

	hbs_divider u_div_y (
		.clk (clk),
		.en  (en),
		.p   (py_s3),
		.d   (dy_s3),
		.q   (qy_d),
		.sat (saty_d)
	);

endmodule

// ===== rtl/hbs_queue.sv =====
module hbs_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hbs_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output hbs_pkg::entry_t head
);

	localparam int DEPTH = hbs_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);

	hbs_pkg::entry_t   mem_q [DEPTH];
	logic [PTR_W-1:0]  wp_q, rp_q;
	logic [PTR_W:0]    cnt_q;

	assign full       = (cnt_q == (PTR_W+1)'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + PTR_W'(1);
			if (pop)  rp_q <= rp_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (PTR_W+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (PTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_entry;
	end

endmodule

// ===== rtl/hbs_back.sv =====
module hbs_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  hbs_pkg::entry_t               head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [hbs_pkg::HEIGHT_W-1:0]  out_height
);

	localparam int ADDR_W   = hbs_pkg::ADDR_W;
	localparam int WGT_W    = hbs_pkg::WGT_W;
	localparam int SUM_W    = hbs_pkg::SUM_W;
	localparam int MQ_W     = hbs_pkg::MQ_W;
	localparam int HEIGHT_W = hbs_pkg::HEIGHT_W;
	localparam int ODEPTH   = hbs_pkg::OUT_DEPTH;
	localparam int OP_W     = $clog2(ODEPTH);

	logic [hbs_pkg::TEXEL_W-1:0] store_mem [hbs_pkg::STORE_DEPTH];

	hbs_pkg::entry_t cur_q;
	logic            cur_v_q;
	logic [1:0]      ph_q;
	logic            done, credit_ok, out_hs;
	logic [OP_W:0]   cr_q;

	logic [hbs_pkg::TEXEL_W-1:0] rdata_q;
	logic                rv_s1, rfirst_s1, rlast_s1;
	logic [WGT_W-1:0]    wgt_s1;
	logic                pv_s2, pfirst_s2, plast_s2;
	logic [SUM_W-1:0]    prod_s2;
	logic [SUM_W-1:0]    acc_q, acc_base;
	logic                fv_s3;
	logic [SUM_W-1:0]    fin_s3;
	logic                mv_s4;
	logic [MQ_W-1:0]     mq_s4;

	logic [HEIGHT_W-1:0] ofifo_q [ODEPTH];
	logic [OP_W-1:0]     owp_q, orp_q;
	logic [OP_W:0]       ocnt_q;

	assign done      = cur_v_q && (!cur_q.is_query || ph_q == 2'd3);
	assign credit_ok = (cr_q != (OP_W+1)'(ODEPTH));
	assign pop       = head_valid && (!cur_v_q || done) && (!head.is_query || credit_ok);
	assign out_hs    = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			ph_q    <= 2'd0;
			cr_q    <= '0;
		end else begin
			if (pop) begin
				cur_v_q <= 1'b1;
				ph_q    <= 2'd0;
			end else begin
				if (done) cur_v_q <= 1'b0;
				if (cur_v_q) ph_q <= ph_q + 2'd1;
			end
			if ((pop && head.is_query) && !out_hs)
				cr_q <= cr_q + (OP_W+1)'(1);
			else if (out_hs && !(pop && head.is_query))
				cr_q <= cr_q - (OP_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
	end

	always_ff @(posedge clk) begin
		if (cur_v_q && !cur_q.is_query && cur_q.wr_ok)
			store_mem[cur_q.addr[0]] <= cur_q.value;
		rdata_q <= store_mem[cur_q.addr[ph_q]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
			pv_s2 <= 1'b0;
			fv_s3 <= 1'b0;
			mv_s4 <= 1'b0;
		end else begin
			rv_s1 <= cur_v_q && cur_q.is_query;
			pv_s2 <= rv_s1;
			fv_s3 <= pv_s2 && plast_s2;
			mv_s4 <= fv_s3;
		end
	end

	assign acc_base = pfirst_s2 ? '0 : acc_q;

	always_ff @(posedge clk) begin
		rfirst_s1 <= (ph_q == 2'd0);
		rlast_s1  <= (ph_q == 2'd3);
		wgt_s1    <= cur_q.wgt[ph_q];
		pfirst_s2 <= rfirst_s1;
		plast_s2  <= rlast_s1;
		prod_s2   <= wgt_s1 * rdata_q;
		if (pv_s2) acc_q <= acc_base + prod_s2;
		fin_s3 <= acc_base + prod_s2 + hbs_pkg::RND_C;
		mq_s4  <= fin_s3[SUM_W-1:hbs_pkg::FRAC_W] * hbs_pkg::RECIP_C;
	end

	assign out_valid  = (ocnt_q != '0);
	assign out_height = ofifo_q[orp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (mv_s4)  owp_q <= owp_q + OP_W'(1);
			if (out_hs) orp_q <= orp_q + OP_W'(1);
			if (mv_s4 && !out_hs)
				ocnt_q <= ocnt_q + (OP_W+1)'(1);
			else if (out_hs && !mv_s4)
				ocnt_q <= ocnt_q - (OP_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (mv_s4)
			ofifo_q[owp_q] <= mq_s4[hbs_pkg::RECIP_SH +: HEIGHT_W] - hbs_pkg::HEIGHT_OFF;
	end

endmodule

// ===== rtl/heightmap_bilinear_sampler_top.sv =====
// Bilinear height-map sampler.
// The slave stream carries one word per item. The tuser bit selects the kind:
// a texel write stores one height byte at a linear map address, a query gives
// a world position in signed Q16.16 and returns one word on the master stream
// with the interpolated height, signed Q3.16, in the low 19 bits.
// Writes return nothing. Results come out in query order.
// The configuration channel sets the world bounds and the map size in use;
// it is always ready and should be written only while the block is idle.
// The front end takes one word per cycle unless the queue is full, and runs a
// 33-stage pipeline with two radix-2 dividers, one quotient bit per stage. A
// query then makes four reads on the single port of the height memory, one per
// neighbor texel, before the next entry is taken; writes go at one per cycle.
// Reset restores the default bounds and a 1024 by 1024 map and empties all
// queues; the height memory keeps no valid state and must be written first.
// When the receiver stalls, up to four results wait in an output queue, then
// the back end stops taking queries, the queue between front and back fills and tready falls.
module heightmap_bilinear_sampler_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,  // texel_addr, texel_value, query_x, query_y, zero pad
	input  logic        s_axis_tuser,  // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // height, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	hbs_pkg::cfg_t   cfg_q;
	hbs_pkg::entry_t push_entry, head;
	logic            push, full, pop, head_valid;
	logic [hbs_pkg::HEIGHT_W-1:0] height;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x   <= -32'sd3355443;
			cfg_q.origin_y   <= -32'sd3355443;
			cfg_q.extent_x   <= 32'sd3355443;
			cfg_q.extent_y   <= 32'sd3355443;
			cfg_q.map_width  <= 11'd1024;
			cfg_q.map_height <= 11'd1024;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hbs_pkg::CFG_ORIGIN_X:   cfg_q.origin_x   <= cfg_data;
				hbs_pkg::CFG_ORIGIN_Y:   cfg_q.origin_y   <= cfg_data;
				hbs_pkg::CFG_EXTENT_X:   cfg_q.extent_x   <= cfg_data;
				hbs_pkg::CFG_EXTENT_Y:   cfg_q.extent_y   <= cfg_data;
				hbs_pkg::CFG_MAP_WIDTH:  cfg_q.map_width  <= cfg_data[10:0];
				hbs_pkg::CFG_MAP_HEIGHT: cfg_q.map_height <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	hbs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_type    (s_axis_tuser),
		.in_addr    (s_axis_tdata[19:0]),
		.in_value   (s_axis_tdata[27:20]),
		.in_qx      (s_axis_tdata[59:28]),
		.in_qy      (s_axis_tdata[91:60]),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	hbs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	hbs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_height (height)
	);

	assign m_axis_tdata = {5'd0, height};

endmodule

// ===== rtl/hbs_checker.sv =====
module hbs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result word dropped while stalled");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[23:19] == 5'd0))
		else $error("padding bits of result word not zero");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[18] == 1'b0 && m_axis_tdata[17:0] > 18'd203162))
		else $error("height above the largest texel value");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind heightmap_bilinear_sampler_top hbs_checker u_hbs_checker (.*);
